// File: hdl/csmabo_pkg.sv
// types, codes and helper functions shared by the station backoff block
`default_nettype none
package csmabo_pkg;

   localparam int unsigned BackoffW = 18;
   localparam int unsigned AirW     = 9;
   localparam int unsigned CsrIdxW  = 3;
   localparam int unsigned CsrDataW = 8;

   localparam logic [BackoffW-1:0] BACKOFF_MAX = '1;

   typedef enum logic [2:0] {
      EV_WAIT    = 3'd0,
      EV_START   = 3'd1,
      EV_DEFER   = 3'd2,
      EV_SUCCESS = 3'd3,
      EV_RETRY   = 3'd4,
      EV_DROP    = 3'd5
   } event_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_FRAME_LEN       = 3'd0,
      CSR_DIFS_SLOTS      = 3'd1,
      CSR_SIFS_ACK_SLOTS  = 3'd2,
      CSR_MAX_BACKOFF_EXP = 3'd3,
      CSR_MAX_ATTEMPTS    = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [7:0] frame_len;
      logic [3:0] difs_slots;
      logic [3:0] sifs_ack_slots;
      logic [3:0] max_backoff_exp;
      logic [7:0] max_attempts;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      frame_len:       8'd4,
      difs_slots:      4'd1,
      sifs_ack_slots:  4'd2,
      max_backoff_exp: 4'd5,
      max_attempts:    8'd8
   };

   typedef struct packed {
      logic        channel_busy;
      logic        others_on_air;
      logic [15:0] random_word;
   } item_type;

   typedef struct packed {
      logic                sending;
      logic                hit_collision;
      logic [3:0]          difs_left;
      logic [BackoffW-1:0] backoff_count;
      logic [7:0]          attempts;
      logic [AirW-1:0]     air_slots_left;
      logic [31:0]         success_counter;
      logic [31:0]         collision_counter;
      logic [31:0]         backoff_counter;
      logic [31:0]         drop_counter;
   } state_type;

   localparam state_type STATE_RESET = '{
      sending:           1'b0,
      hit_collision:     1'b0,
      difs_left:         4'd1,
      backoff_count:     '0,
      attempts:          8'd0,
      air_slots_left:    '0,
      success_counter:   32'd0,
      collision_counter: 32'd0,
      backoff_counter:   32'd0,
      drop_counter:      32'd0
   };

   function automatic logic [31:0] sat_inc32(input logic [31:0] v);
      return (v == '1) ? v : v + 32'd1;
   endfunction

   function automatic logic [7:0] sat_inc8(input logic [7:0] v);
      return (v == '1) ? v : v + 8'd1;
   endfunction

endpackage
`default_nettype wire

// File: hdl/csmabo_draw.sv
// backoff draw: window exponent, scaled random count, slot multiply, saturation
`default_nettype none
module csmabo_draw (
   input  wire logic [7:0]                     attempts,
   input  wire logic [3:0]                     max_backoff_exp,
   input  wire logic [15:0]                    random_word,
   input  wire logic [7:0]                     frame_len,
   output logic      [csmabo_pkg::BackoffW-1:0] backoff
);
   import csmabo_pkg::*;

   logic [3:0]  exp_n;
   logic [30:0] shifted;
   logic [14:0] k;
   logic [22:0] product;

   always_comb begin
      // exponent is the smaller of attempts and the cap
      if (attempts < {4'd0, max_backoff_exp}) begin
         exp_n = attempts[3:0];
      end else begin
         exp_n = max_backoff_exp;
      end
      shifted = {15'd0, random_word} << exp_n;
      k       = shifted[30:16];
      product = {8'd0, k} * {15'd0, frame_len};
      if (product > {5'd0, BACKOFF_MAX}) begin
         backoff = BACKOFF_MAX;
      end else begin
         backoff = product[BackoffW-1:0];
      end
   end

endmodule
`default_nettype wire

// File: hdl/csmabo_step.sv
// per-slot next state: access phase then air phase
`default_nettype none
module csmabo_step (
   input  wire csmabo_pkg::cfg_type   cfg,
   input  wire csmabo_pkg::state_type cur,
   input  wire csmabo_pkg::item_type  item,
   output csmabo_pkg::state_type      nxt,
   output csmabo_pkg::event_type      ev
);
   import csmabo_pkg::*;

   logic [7:0]          attempts_inc;
   logic [BackoffW-1:0] drawn;
   logic                done;

   // at most one draw per slot, always from the incremented attempt count
   assign attempts_inc = sat_inc8(cur.attempts);

   csmabo_draw u_draw (
      .attempts        (attempts_inc),
      .max_backoff_exp (cfg.max_backoff_exp),
      .random_word     (item.random_word),
      .frame_len       (cfg.frame_len),
      .backoff         (drawn)
   );

   always_comb begin
      nxt  = cur;
      ev   = EV_WAIT;
      done = 1'b0;

      // access phase
      if (!cur.sending) begin
         if (!item.channel_busy) begin
            if (cur.difs_left != 4'd0) begin
               nxt.difs_left = cur.difs_left - 4'd1;
            end else if (cur.backoff_count != '0) begin
               nxt.backoff_count = cur.backoff_count - BackoffW'(1);
            end else begin
               nxt.sending        = 1'b1;
               nxt.air_slots_left = {1'b0, cfg.frame_len} + {5'd0, cfg.sifs_ack_slots};
               ev                 = EV_START;
            end
         end else if (cur.backoff_count == '0) begin
            nxt.attempts        = attempts_inc;
            nxt.backoff_counter = sat_inc32(cur.backoff_counter);
            nxt.difs_left       = cfg.difs_slots;
            nxt.backoff_count   = drawn;
            ev                  = EV_DEFER;
         end
      end

      // air phase
      if (nxt.sending) begin
         if (nxt.difs_left != 4'd0) begin
            nxt.difs_left = nxt.difs_left - 4'd1;
         end else if (nxt.air_slots_left <= AirW'(1)) begin
            nxt.air_slots_left = '0;
            done               = 1'b1;
         end else begin
            nxt.air_slots_left = nxt.air_slots_left - AirW'(1);
         end
         if (item.others_on_air) begin
            nxt.hit_collision = 1'b1;
         end
         if (done) begin
            nxt.attempts = attempts_inc;
            if (nxt.hit_collision) begin
               nxt.collision_counter = sat_inc32(cur.collision_counter);
               nxt.backoff_counter   = sat_inc32(cur.backoff_counter);
               if (attempts_inc < cfg.max_attempts) begin
                  nxt.backoff_count = drawn;
                  ev                = EV_RETRY;
               end else begin
                  nxt.drop_counter  = sat_inc32(cur.drop_counter);
                  nxt.attempts      = 8'd0;
                  nxt.backoff_count = '0;
                  ev                = EV_DROP;
               end
            end else begin
               nxt.attempts        = 8'd0;
               nxt.success_counter = sat_inc32(cur.success_counter);
               nxt.backoff_count   = '0;
               ev                  = EV_SUCCESS;
            end
            nxt.difs_left     = cfg.difs_slots;
            nxt.hit_collision = 1'b0;
            nxt.sending       = 1'b0;
         end
      end
   end

endmodule
`default_nettype wire

// File: hdl/csma_ca_station_backoff.sv
// top level of one csma/ca station with binary exponential backoff
//
//   channel | dir | handshake            | payload
//   --------+-----+----------------------+-------------------------------------------
//   req     | in  | req_valid/req_ready  | channel_busy, others_on_air, random_word
//   rsp     | out | rsp_valid/rsp_ready  | event_res, on_air, backoff_left,
//           |     |                      | attempt_count, four saturating totals
//   csr     | in  | csr_we               | csr_index, csr_wdata (no read-back)
//
// one beat per cycle sustained while rsp is not stalled; a req beat that is taken
// passes the input register, one pass of slot logic and the result register
// reset clears station state to idle with one difs slot pending and loads
// the default register values
// a stalled rsp holds the input register; req_ready then drops only once
// that register is also full, so one beat waits per side
`default_nettype none
module csma_ca_station_backoff (
   input  wire logic                             clock,
   input  wire logic                             reset,

   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic                             req_channel_busy,
   input  wire logic                             req_others_on_air,
   input  wire logic [15:0]                      req_random_word,

   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic      [2:0]                       rsp_event_res,
   output logic                                  rsp_on_air,
   output logic      [csmabo_pkg::BackoffW-1:0]  rsp_backoff_left,
   output logic      [7:0]                       rsp_attempt_count,
   output logic      [31:0]                      rsp_success_total,
   output logic      [31:0]                      rsp_collision_total,
   output logic      [31:0]                      rsp_backoff_total,
   output logic      [31:0]                      rsp_dropped_total,

   input  wire logic                             csr_we,
   input  wire logic [csmabo_pkg::CsrIdxW-1:0]   csr_index,
   input  wire logic [csmabo_pkg::CsrDataW-1:0]  csr_wdata
);
   import csmabo_pkg::*;

   // input register
   logic      in_valid_ff;
   item_type  in_item_ff;

   // station state, written only when a slot result is loaded
   state_type state_ff;
   state_type state_in;

   // result register: the event code is held here, everything else is the
   // station state, which cannot move while the result waits
   logic      rsp_valid_ff;
   event_type ev_ff;
   event_type ev_in;

   // configuration registers
   cfg_type   cfg_ff;
   cfg_type   cfg_in;

   logic      out_free;
   logic      fire;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || fire;

   csmabo_step u_step (
      .cfg  (cfg_ff),
      .cur  (state_ff),
      .item (in_item_ff),
      .nxt  (state_in),
      .ev   (ev_in)
   );

   // register write decode, unknown indexes are ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_FRAME_LEN:       cfg_in.frame_len       = csr_wdata;
            CSR_DIFS_SLOTS:      cfg_in.difs_slots      = csr_wdata[3:0];
            CSR_SIFS_ACK_SLOTS:  cfg_in.sifs_ack_slots  = csr_wdata[3:0];
            CSR_MAX_BACKOFF_EXP: cfg_in.max_backoff_exp = csr_wdata[3:0];
            CSR_MAX_ATTEMPTS:    cfg_in.max_attempts    = csr_wdata;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   // control and state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
         cfg_ff       <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (fire) begin
            state_ff <= state_in;
         end
         rsp_valid_ff <= fire || (rsp_valid_ff && !rsp_ready);
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff.channel_busy  <= req_channel_busy;
         in_item_ff.others_on_air <= req_others_on_air;
         in_item_ff.random_word   <= req_random_word;
      end
      if (fire) begin
         ev_ff <= ev_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_event_res       = ev_ff;
   assign rsp_on_air          = state_ff.sending;
   assign rsp_backoff_left    = state_ff.backoff_count;
   assign rsp_attempt_count   = state_ff.attempts;
   assign rsp_success_total   = state_ff.success_counter;
   assign rsp_collision_total = state_ff.collision_counter;
   assign rsp_backoff_total   = state_ff.backoff_counter;
   assign rsp_dropped_total   = state_ff.drop_counter;

`ifndef ASSERT_OFF
   // a frame that starts and does not end in the same slot is on air
   a_start_on_air: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (ev_ff == EV_START) |-> rsp_on_air)
      else $error("start event without station on air");

   // frame end with success or drop leaves a clean station
   a_end_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((ev_ff == EV_SUCCESS) || (ev_ff == EV_DROP)) |->
      !rsp_on_air && (rsp_attempt_count == 8'd0) && (rsp_backoff_left == '0))
      else $error("success or drop left attempts, backoff or air state");

   // collision flag only lives during a transmission
   a_hit_needs_air: assert property (@(posedge clock) disable iff (reset)
      !state_ff.sending |-> !state_ff.hit_collision)
      else $error("collision latched while not on air");

   // the backoff total moves only when a slot result is loaded
   a_totals_on_fire: assert property (@(posedge clock) disable iff (reset)
      !$stable(state_ff.backoff_counter) |-> $past(fire))
      else $error("backoff total changed without a slot");
`endif

endmodule
`default_nettype wire
